>>> rtl/core/gpr_pkg.sv
// Shared types and constants of the glyph-to-pixel-row renderer.
// Used by the register block, controller, datapath and top level.
`default_nettype none

package gpr_pkg;

   localparam int MAX_GLYPH_COLS = 8;
   localparam int CSR_ADDR_W     = 5;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_DRAW = 1'b1;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_FB     = 2'd1;
   localparam logic [1:0] ST_NO_FONT   = 2'd2;
   localparam logic [1:0] ST_BAD_DEPTH = 2'd3;

   typedef enum logic [2:0] {
      REG_FB_PRESENT   = 3'd0,
      REG_RED_LAYOUT   = 3'd1,
      REG_GREEN_LAYOUT = 3'd2,
      REG_BLUE_LAYOUT  = 3'd3,
      REG_BPP          = 3'd4,
      REG_LINE_PITCH   = 3'd5,
      REG_FONT_WIDTH   = 3'd6,
      REG_FONT_HEIGHT  = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic        fb_present;
      logic [9:0]  red_layout;
      logic [9:0]  green_layout;
      logic [9:0]  blue_layout;
      logic [5:0]  bits_per_pixel;
      logic [17:0] line_pitch;
      logic [3:0]  font_width;
      logic [4:0]  font_height;
   } cfg_type;

   typedef struct packed {
      logic [7:0]  char_code;
      logic [3:0]  glyph_row;
      logic [7:0]  font_byte;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [23:0] fg_color;
      logic [23:0] bg_color;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [34:0]      row_offset;
      logic [3:0]       pixel_count;
      logic [7:0][31:0] pixels;
      logic             last;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic       store;
      logic       capture;
      logic       mult;
      logic       form;
      logic       row_load;
      logic       status_load;
      logic       last;
      logic [1:0] status;
   } cmd_type;

   // Bytes per pixel for a depth; zero for an unsupported depth
   function automatic logic [2:0] depth_bytes(logic [5:0] bpp);
      logic [2:0] b;
      unique case (bpp)
         6'd15, 6'd16: b = 3'd2;
         6'd24:        b = 3'd3;
         6'd32:        b = 3'd4;
         default:      b = 3'd0;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/glyph_to_pixel_row_renderer.sv
// Glyph-to-pixel-row renderer: top level, stream and APB-style ports.
// Instantiates gpr_csr, gpr_ctrl and gpr_datapath; uses gpr_pkg.
//
// A load item (tuser 0) writes one glyph row byte into the glyph store. A draw
// item (tuser 1) first runs its setup (take the item, channel and offset
// multiplies, then scaling, offset sum and the read of the first glyph row) and
// then gives one result per glyph row, one per cycle while the result side
// keeps up, the most that the single read port of the glyph store allows:
// font_height results, saturated at MAX_GLYPH_ROWS. A draw that hits a missing
// framebuffer, missing font or unsupported depth presents one status result
// instead, once the output register is free. The glyph store has no reset;
// draw only glyph rows that were loaded. Results sit in an output register,
// so the next item is taken while a result waits only once the current draw
// has issued its final row.
`default_nettype none

module glyph_to_pixel_row_renderer
   import gpr_pkg::*;
#(
   parameter int GLYPH_COUNT    = 256,
   parameter int MAX_GLYPH_ROWS = 16
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // char_code[7:0], glyph_row[11:8], font_byte[19:12], pos_x[35:20],
   // pos_y[51:36], fg_color[75:52], bg_color[99:76], zero fill[103:100]
   input  wire logic [103:0]          req_tdata,
   // kind[0]
   input  wire logic                  req_tuser,
   // result stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // status[1:0], row_offset[36:2], pixel_count[40:37], pixel_0[72:41],
   // pixel_1..pixel_7 in further 32-bit slots up to [296:265], zero fill[303:297]
   output logic [303:0]               rsp_tdata,
   output logic                       rsp_tlast,
   // configuration port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   localparam int RowW = $clog2(MAX_GLYPH_ROWS);

   cfg_type         cfg;
   req_type         req;
   rsp_type         rsp;
   cmd_type         cmd;
   logic [RowW-1:0] rd_row;

   assign req.char_code = req_tdata[7:0];
   assign req.glyph_row = req_tdata[11:8];
   assign req.font_byte = req_tdata[19:12];
   assign req.pos_x     = req_tdata[35:20];
   assign req.pos_y     = req_tdata[51:36];
   assign req.fg_color  = req_tdata[75:52];
   assign req.bg_color  = req_tdata[99:76];

   assign rsp_tdata = {7'd0, rsp.pixels, rsp.pixel_count, rsp.row_offset, rsp.status};
   assign rsp_tlast = rsp.last;

   gpr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   gpr_ctrl #(
      .MAX_GLYPH_ROWS (MAX_GLYPH_ROWS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .rd_row     (rd_row)
   );

   gpr_datapath #(
      .GLYPH_COUNT    (GLYPH_COUNT),
      .MAX_GLYPH_ROWS (MAX_GLYPH_ROWS)
   ) u_datapath (
      .clock  (clock),
      .cfg    (cfg),
      .req    (req),
      .cmd    (cmd),
      .rd_row (rd_row),
      .rsp    (rsp)
   );

endmodule

`default_nettype wire

>>> rtl/core/gpr_csr.sv
// Configuration registers of the renderer behind an APB-style port.
// Depends on gpr_pkg for the register map and the cfg_type struct.
`default_nettype none

module gpr_csr
   import gpr_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready,
   output cfg_type                    cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign idx        = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_FB_PRESENT:   cfg_in.fb_present     = csr_pwdata[0];
            REG_RED_LAYOUT:   cfg_in.red_layout     = csr_pwdata[9:0];
            REG_GREEN_LAYOUT: cfg_in.green_layout   = csr_pwdata[9:0];
            REG_BLUE_LAYOUT:  cfg_in.blue_layout    = csr_pwdata[9:0];
            REG_BPP:          cfg_in.bits_per_pixel = csr_pwdata[5:0];
            REG_LINE_PITCH:   cfg_in.line_pitch     = csr_pwdata[17:0];
            REG_FONT_WIDTH:   cfg_in.font_width     = csr_pwdata[3:0];
            REG_FONT_HEIGHT:  cfg_in.font_height    = csr_pwdata[4:0];
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_FB_PRESENT:   csr_prdata = 32'(cfg_ff.fb_present);
         REG_RED_LAYOUT:   csr_prdata = 32'(cfg_ff.red_layout);
         REG_GREEN_LAYOUT: csr_prdata = 32'(cfg_ff.green_layout);
         REG_BLUE_LAYOUT:  csr_prdata = 32'(cfg_ff.blue_layout);
         REG_BPP:          csr_prdata = 32'(cfg_ff.bits_per_pixel);
         REG_LINE_PITCH:   csr_prdata = 32'(cfg_ff.line_pitch);
         REG_FONT_WIDTH:   csr_prdata = 32'(cfg_ff.font_width);
         REG_FONT_HEIGHT:  csr_prdata = 32'(cfg_ff.font_height);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff                <= '0;
         cfg_ff.bits_per_pixel <= 6'd32;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/gpr_ctrl.sv
// Controller state machine of the renderer: handshakes, error checks, row sequencing.
// Depends on gpr_pkg; drives the datapath through cmd_type.
`default_nettype none

module gpr_ctrl
   import gpr_pkg::*;
#(
   parameter int MAX_GLYPH_ROWS = 16,
   localparam int RowW = $clog2(MAX_GLYPH_ROWS)
)
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  cfg_type              cfg,
   input  wire logic            req_tvalid,
   input  wire logic            req_kind,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  wire logic            rsp_tready,
   output cmd_type              cmd,
   output logic [RowW-1:0]      rd_row
);

   localparam int HgtW = $clog2(MAX_GLYPH_ROWS + 1);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_MULT = 5'b00010,
      S_FORM = 5'b00100,
      S_ROWS = 5'b01000,
      S_STAT = 5'b10000
   } state_type;

   state_type       state_ff, state_in;
   logic [HgtW-1:0] row_ff, row_in;
   logic [1:0]      stat_ff, stat_in;
   logic            valid_ff, valid_in;

   logic            accept;
   logic            out_free;
   logic [1:0]      err;
   logic [HgtW-1:0] hgt;
   logic            row_last;
   logic [HgtW-1:0] row_next;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign out_free   = ~valid_ff | rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign row_next   = row_ff + HgtW'(1);

   always_comb begin
      if (6'(cfg.font_height) > 6'(MAX_GLYPH_ROWS)) begin
         hgt = HgtW'(MAX_GLYPH_ROWS);
      end else begin
         hgt = HgtW'(cfg.font_height);
      end
   end

   assign row_last = ((HgtW+1)'(row_ff) + (HgtW+1)'(1)) == (HgtW+1)'(hgt);

   always_comb begin
      priority if (!cfg.fb_present) begin
         err = ST_NO_FB;
      end else if (cfg.font_width == 4'd0 || cfg.font_height == 5'd0) begin
         err = ST_NO_FONT;
      end else if (depth_bytes(cfg.bits_per_pixel) == 3'd0) begin
         err = ST_BAD_DEPTH;
      end else begin
         err = ST_OK;
      end
   end

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      stat_in  = stat_ff;
      cmd      = '0;
      rd_row   = row_ff[RowW-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_LOAD) begin
                  cmd.store = 1'b1;
               end else if (err == ST_OK) begin
                  cmd.capture = 1'b1;
                  state_in    = S_MULT;
               end else begin
                  stat_in  = err;
                  state_in = S_STAT;
               end
            end
         end
         S_MULT: begin
            cmd.mult = 1'b1;
            state_in = S_FORM;
         end
         S_FORM: begin
            // issue the read of glyph row 0
            cmd.form = 1'b1;
            row_in   = '0;
            rd_row   = '0;
            state_in = S_ROWS;
         end
         S_ROWS: begin
            if (out_free) begin
               cmd.row_load = 1'b1;
               cmd.last     = row_last;
               cmd.status   = ST_OK;
               if (row_last) begin
                  state_in = S_IDLE;
               end else begin
                  // prefetch the next row so one row leaves per cycle while the output is free
                  row_in = row_next;
                  rd_row = row_next[RowW-1:0];
               end
            end
         end
         S_STAT: begin
            if (out_free) begin
               cmd.status_load = 1'b1;
               cmd.last        = 1'b1;
               cmd.status      = stat_ff;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.row_load || cmd.status_load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         row_ff   <= '0;
         stat_ff  <= ST_OK;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         stat_ff  <= stat_in;
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/gpr_datapath.sv
// Datapath of the renderer: glyph store, color scaling, row offset and result register.
// Depends on gpr_pkg; steered by gpr_ctrl through cmd_type.
`default_nettype none

module gpr_datapath
   import gpr_pkg::*;
#(
   parameter int GLYPH_COUNT    = 256,
   parameter int MAX_GLYPH_ROWS = 16,
   localparam int RowW = $clog2(MAX_GLYPH_ROWS)
)
(
   input  wire logic       clock,
   input  cfg_type         cfg,
   input  req_type         req,
   input  cmd_type         cmd,
   input  wire logic [RowW-1:0] rd_row,
   output rsp_type         rsp
);

   localparam int CodeW = $clog2(GLYPH_COUNT);
   localparam int Depth = GLYPH_COUNT * MAX_GLYPH_ROWS;
   localparam int AddrW = $clog2(Depth);

   // c * (2^size - 1), size clamped to 8
   function automatic logic [15:0] chan_product(logic [7:0] c, logic [9:0] layout);
      logic [3:0] sz;
      logic [8:0] maxv;
      sz   = (layout[4:0] > 5'd8) ? 4'd8 : layout[3:0];
      maxv = (9'd1 << sz) - 9'd1;
      return 16'(c) * 16'(maxv[7:0]);
   endfunction

   // floor(x / 255) for x below 65280
   function automatic logic [7:0] div255(logic [15:0] x);
      logic [16:0] t;
      t = 17'(x) + 17'(x[15:8]) + 17'd1;
      return t[15:8];
   endfunction

   logic [7:0]       mem [Depth];
   logic [7:0]       rd_data_ff;

   logic [CodeW-1:0] code_ff;
   logic [15:0]      px_ff;
   logic [15:0]      py_ff;
   logic [23:0]      fg_ff;
   logic [23:0]      bg_ff;
   logic [2:0][15:0] fg_prod_ff;
   logic [2:0][15:0] bg_prod_ff;
   logic [33:0]      basey_ff;
   logic [17:0]      pxb_ff;
   logic [31:0]      fgp_ff, fgp_in;
   logic [31:0]      bgp_ff, bgp_in;
   logic [34:0]      offset_ff;
   rsp_type          rsp_ff, rsp_in;

   logic [8:0]       code_ext;
   logic [CodeW-1:0] code_mod;
   logic [5:0]       row_ext;
   logic [RowW-1:0]  row_mod;
   logic [AddrW-1:0] waddr;
   logic [AddrW-1:0] raddr;
   logic [2:0][9:0]  lay;
   logic [2:0]       bytes;
   logic [31:0]      mask;
   logic [3:0]       width;

   // wrap code and row into the store
   always_comb begin
      code_ext = {1'b0, req.char_code};
      if (code_ext >= 9'(GLYPH_COUNT)) begin
         code_ext = code_ext - 9'(GLYPH_COUNT);
      end
      code_mod = code_ext[CodeW-1:0];
      row_ext  = {2'b00, req.glyph_row};
      if (row_ext >= 6'(MAX_GLYPH_ROWS)) begin
         row_ext = row_ext - 6'(MAX_GLYPH_ROWS);
      end
      row_mod = row_ext[RowW-1:0];
   end

   assign waddr = AddrW'(code_mod) * AddrW'(MAX_GLYPH_ROWS) + AddrW'(row_mod);
   assign raddr = AddrW'(code_ff) * AddrW'(MAX_GLYPH_ROWS) + AddrW'(rd_row);

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         mem[waddr] <= req.font_byte;
      end
      rd_data_ff <= mem[raddr];
   end

   assign lay[0] = cfg.red_layout;
   assign lay[1] = cfg.green_layout;
   assign lay[2] = cfg.blue_layout;
   assign bytes  = depth_bytes(cfg.bits_per_pixel);
   assign width  = (cfg.font_width > 4'(MAX_GLYPH_COLS)) ? 4'(MAX_GLYPH_COLS) : cfg.font_width;

   always_comb begin
      unique case (bytes)
         3'd2:    mask = 32'h0000_FFFF;
         3'd3:    mask = 32'h00FF_FFFF;
         default: mask = 32'hFFFF_FFFF;
      endcase
   end

   always_comb begin
      fgp_in = '0;
      bgp_in = '0;
      for (int i = 0; i < 3; i++) begin
         fgp_in = fgp_in | (32'(div255(fg_prod_ff[i])) << lay[i][9:5]);
         bgp_in = bgp_in | (32'(div255(bg_prod_ff[i])) << lay[i][9:5]);
      end
      fgp_in = fgp_in & mask;
      bgp_in = bgp_in & mask;
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.row_load) begin
         rsp_in.status      = cmd.status;
         rsp_in.row_offset  = offset_ff;
         rsp_in.pixel_count = width;
         rsp_in.last        = cmd.last;
         for (int c = 0; c < MAX_GLYPH_COLS; c++) begin
            if (4'(c) < width) begin
               rsp_in.pixels[c] = rd_data_ff[MAX_GLYPH_COLS-1-c] ? fgp_ff : bgp_ff;
            end else begin
               rsp_in.pixels[c] = '0;
            end
         end
      end else if (cmd.status_load) begin
         rsp_in        = '0;
         rsp_in.status = cmd.status;
         rsp_in.last   = cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         code_ff <= code_mod;
         px_ff   <= req.pos_x;
         py_ff   <= req.pos_y;
         fg_ff   <= req.fg_color;
         bg_ff   <= req.bg_color;
      end
      if (cmd.mult) begin
         for (int i = 0; i < 3; i++) begin
            fg_prod_ff[i] <= chan_product(fg_ff[23-8*i -: 8], lay[i]);
            bg_prod_ff[i] <= chan_product(bg_ff[23-8*i -: 8], lay[i]);
         end
         basey_ff <= 34'(py_ff) * 34'(cfg.line_pitch);
         pxb_ff   <= 18'(px_ff) * 18'(bytes);
      end
      if (cmd.form) begin
         fgp_ff    <= fgp_in;
         bgp_ff    <= bgp_in;
         offset_ff <= 35'(basey_ff) + 35'(pxb_ff);
      end else if (cmd.row_load) begin
         // advance one scanline
         offset_ff <= offset_ff + 35'(cfg.line_pitch);
      end
      rsp_ff <= rsp_in;
   end

   assign rsp = rsp_ff;

endmodule

`default_nettype wire
